FILE: design/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared widths, types and helpers for the circle and triangle bounce block.
// ----------------------------------------------------------------------------
package ctb_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int CW  = 24;          // coordinate width
    localparam int RW  = CW - 1;      // radius width
    localparam int DW  = CW + 1;      // difference width
    localparam int PW  = 2 * DW;      // product of two differences
    localparam int SW  = PW + 2;      // sum of products
    localparam int HW  = SW / 2;      // half of a sum, for split products
    localparam int XW  = 2 * SW;      // square of a sum
    localparam int MW  = HW + DW;     // half sum times a difference
    localparam int QW  = CW + 2;      // quotient bits of the reflection term
    localparam int NW  = SW + QW + 2; // dividend and remainder width
    localparam int NE  = 3;           // triangle edges
    localparam int EW  = 2;           // edge index width
    localparam int FD  = 4;           // queue depth
    localparam int FAW = 2;           // queue pointer width

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic        [SW-1:0] usum_t;

    // One classified request passed from the front to the back.
    typedef struct packed {
        logic          hit;
        logic [EW-1:0] edge_idx;
        diff_t         dx;
        diff_t         dy;
        usum_t         len2;
        coord_t        vx;
        coord_t        vy;
    } ctb_item_t;

    // Sideband carried alongside the dividers.
    typedef struct packed {
        logic          lz;
        logic          hit;
        logic [EW-1:0] edge_idx;
        logic          sgx;
        logic          sgy;
        coord_t        vx;
        coord_t        vy;
    } ctb_side_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } ctb_fifo_stat_t;

    // Adds or subtracts a correction term and saturates to the coordinate range.
    function automatic coord_t sat_add(coord_t v, logic neg, logic [QW:0] q);
        logic signed [QW+1:0] qs;
        logic signed [QW+1:0] s;
        qs = $signed({1'b0, q});
        s  = (QW+2)'(v) + (neg ? -qs : qs);
        if (s[QW+1] && !(&s[QW:CW-1])) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else if (!s[QW+1] && (|s[QW:CW-1])) begin
            return {1'b0, {(CW-1){1'b1}}};
        end
        return s[CW-1:0];
    endfunction

endpackage

FILE: design/ctb_front.sv
// ----------------------------------------------------------------------------
// ctb_front
// Accepts requests and finds the first triangle edge touched by the circle.
// ----------------------------------------------------------------------------
module ctb_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ctb_pkg::coord_t       s_center_x,
    input  ctb_pkg::coord_t       s_center_y,
    input  logic [ctb_pkg::RW-1:0] s_radius,
    input  ctb_pkg::coord_t       s_vel_x,
    input  ctb_pkg::coord_t       s_vel_y,
    input  ctb_pkg::coord_t       s_vert0_x,
    input  ctb_pkg::coord_t       s_vert0_y,
    input  ctb_pkg::coord_t       s_vert1_x,
    input  ctb_pkg::coord_t       s_vert1_y,
    input  ctb_pkg::coord_t       s_vert2_x,
    input  ctb_pkg::coord_t       s_vert2_y,
    input  ctb_pkg::ctb_fifo_stat_t fifo_stat,
    output logic                  fifo_push,
    output ctb_pkg::ctb_item_t    fifo_item
);

    localparam int NS = 7;
    localparam int NE = ctb_pkg::NE;
    localparam int SW = ctb_pkg::SW;
    localparam int HW = ctb_pkg::HW;
    localparam int XW = ctb_pkg::XW;

    function automatic int nxt(int i);
        return (i == NE - 1) ? 0 : i + 1;
    endfunction

    logic [NS-1:0] vld_reg;
    logic          adv;

    ctb_pkg::coord_t vtx_x [NE];
    ctb_pkg::coord_t vtx_y [NE];

    // Stage 1: differences.
    ctb_pkg::diff_t dx1_reg [NE], dy1_reg [NE], px1_reg [NE], py1_reg [NE];
    ctb_pkg::diff_t qx1_reg [NE], qy1_reg [NE];
    logic [ctb_pkg::RW-1:0] r1_reg;
    ctb_pkg::coord_t vx1_reg, vy1_reg;
    // Stage 2: products.
    ctb_pkg::prod_t lla2_reg [NE], llb2_reg [NE], dta2_reg [NE], dtb2_reg [NE];
    ctb_pkg::prod_t ppa2_reg [NE], ppb2_reg [NE], qqa2_reg [NE], qqb2_reg [NE];
    ctb_pkg::prod_t cra2_reg [NE], crb2_reg [NE];
    ctb_pkg::diff_t dx2_reg [NE], dy2_reg [NE];
    ctb_pkg::usum_t rr2_reg;
    ctb_pkg::coord_t vx2_reg, vy2_reg;
    // Stage 3: sums.
    ctb_pkg::sum_t len3_reg [NE], dot3_reg [NE], dp3_reg [NE], dq3_reg [NE];
    ctb_pkg::sum_t cr3_reg [NE];
    ctb_pkg::diff_t dx3_reg [NE], dy3_reg [NE];
    ctb_pkg::usum_t rr3_reg;
    ctb_pkg::coord_t vx3_reg, vy3_reg;
    // Stage 4: region of the projection and magnitude of the cross product.
    logic [NE-1:0] near4_reg, far4_reg;
    ctb_pkg::usum_t acr4_reg [NE], len4_reg [NE], dp4_reg [NE], dq4_reg [NE];
    ctb_pkg::diff_t dx4_reg [NE], dy4_reg [NE];
    ctb_pkg::usum_t rr4_reg;
    ctb_pkg::coord_t vx4_reg, vy4_reg;
    // Stage 5: end point tests and split partial products.
    logic [NE-1:0] near5_reg, far5_reg, dpok5_reg, dqok5_reg;
    ctb_pkg::usum_t cll5_reg [NE], clh5_reg [NE], chh5_reg [NE];
    ctb_pkg::usum_t r005_reg [NE], r015_reg [NE], r105_reg [NE], r115_reg [NE];
    ctb_pkg::usum_t len5_reg [NE];
    ctb_pkg::diff_t dx5_reg [NE], dy5_reg [NE];
    ctb_pkg::coord_t vx5_reg, vy5_reg;
    // Stage 6: wide square of the cross product and wide product of radius and length squares.
    logic [NE-1:0] near6_reg, far6_reg, dpok6_reg, dqok6_reg;
    logic [XW-1:0] csq6_reg [NE], rl6_reg [NE];
    ctb_pkg::usum_t len6_reg [NE];
    ctb_pkg::diff_t dx6_reg [NE], dy6_reg [NE];
    ctb_pkg::coord_t vx6_reg, vy6_reg;
    // Stage 7: classified request.
    ctb_pkg::ctb_item_t item_reg, item_next;
    logic [NE-1:0] touch;

    assign vtx_x[0] = s_vert0_x;
    assign vtx_x[1] = s_vert1_x;
    assign vtx_x[2] = s_vert2_x;
    assign vtx_y[0] = s_vert0_y;
    assign vtx_y[1] = s_vert1_y;
    assign vtx_y[2] = s_vert2_y;

    // The whole front moves together unless the last stage cannot leave.
    assign adv       = !vld_reg[NS-1] || !fifo_stat.full;
    assign s_ready   = adv;
    assign fifo_push = vld_reg[NS-1] && !fifo_stat.full;
    assign fifo_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], s_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NE; i++) begin
                dx1_reg[i] <= ctb_pkg::DW'(vtx_x[nxt(i)]) - ctb_pkg::DW'(vtx_x[i]);
                dy1_reg[i] <= ctb_pkg::DW'(vtx_y[nxt(i)]) - ctb_pkg::DW'(vtx_y[i]);
                px1_reg[i] <= ctb_pkg::DW'(s_center_x) - ctb_pkg::DW'(vtx_x[i]);
                py1_reg[i] <= ctb_pkg::DW'(s_center_y) - ctb_pkg::DW'(vtx_y[i]);
                qx1_reg[i] <= ctb_pkg::DW'(s_center_x) - ctb_pkg::DW'(vtx_x[nxt(i)]);
                qy1_reg[i] <= ctb_pkg::DW'(s_center_y) - ctb_pkg::DW'(vtx_y[nxt(i)]);

                lla2_reg[i] <= dx1_reg[i] * dx1_reg[i];
                llb2_reg[i] <= dy1_reg[i] * dy1_reg[i];
                dta2_reg[i] <= px1_reg[i] * dx1_reg[i];
                dtb2_reg[i] <= py1_reg[i] * dy1_reg[i];
                ppa2_reg[i] <= px1_reg[i] * px1_reg[i];
                ppb2_reg[i] <= py1_reg[i] * py1_reg[i];
                qqa2_reg[i] <= qx1_reg[i] * qx1_reg[i];
                qqb2_reg[i] <= qy1_reg[i] * qy1_reg[i];
                cra2_reg[i] <= px1_reg[i] * dy1_reg[i];
                crb2_reg[i] <= py1_reg[i] * dx1_reg[i];
                dx2_reg[i]  <= dx1_reg[i];
                dy2_reg[i]  <= dy1_reg[i];

                len3_reg[i] <= SW'(lla2_reg[i]) + SW'(llb2_reg[i]);
                dot3_reg[i] <= SW'(dta2_reg[i]) + SW'(dtb2_reg[i]);
                dp3_reg[i]  <= SW'(ppa2_reg[i]) + SW'(ppb2_reg[i]);
                dq3_reg[i]  <= SW'(qqa2_reg[i]) + SW'(qqb2_reg[i]);
                cr3_reg[i]  <= SW'(cra2_reg[i]) - SW'(crb2_reg[i]);
                dx3_reg[i]  <= dx2_reg[i];
                dy3_reg[i]  <= dy2_reg[i];

                near4_reg[i] <= (dot3_reg[i] <= 0);
                far4_reg[i]  <= (dot3_reg[i] >= len3_reg[i]);
                acr4_reg[i]  <= cr3_reg[i][SW-1] ? $unsigned(-cr3_reg[i])
                                                 : $unsigned(cr3_reg[i]);
                len4_reg[i]  <= $unsigned(len3_reg[i]);
                dp4_reg[i]   <= $unsigned(dp3_reg[i]);
                dq4_reg[i]   <= $unsigned(dq3_reg[i]);
                dx4_reg[i]   <= dx3_reg[i];
                dy4_reg[i]   <= dy3_reg[i];

                near5_reg[i] <= near4_reg[i];
                far5_reg[i]  <= far4_reg[i];
                dpok5_reg[i] <= (dp4_reg[i] <= rr4_reg);
                dqok5_reg[i] <= (dq4_reg[i] <= rr4_reg);
                cll5_reg[i]  <= acr4_reg[i][HW-1:0] * acr4_reg[i][HW-1:0];
                clh5_reg[i]  <= acr4_reg[i][HW-1:0] * acr4_reg[i][SW-1:HW];
                chh5_reg[i]  <= acr4_reg[i][SW-1:HW] * acr4_reg[i][SW-1:HW];
                r005_reg[i]  <= rr4_reg[HW-1:0] * len4_reg[i][HW-1:0];
                r015_reg[i]  <= rr4_reg[HW-1:0] * len4_reg[i][SW-1:HW];
                r105_reg[i]  <= rr4_reg[SW-1:HW] * len4_reg[i][HW-1:0];
                r115_reg[i]  <= rr4_reg[SW-1:HW] * len4_reg[i][SW-1:HW];
                len5_reg[i]  <= len4_reg[i];
                dx5_reg[i]   <= dx4_reg[i];
                dy5_reg[i]   <= dy4_reg[i];

                near6_reg[i] <= near5_reg[i];
                far6_reg[i]  <= far5_reg[i];
                dpok6_reg[i] <= dpok5_reg[i];
                dqok6_reg[i] <= dqok5_reg[i];
                csq6_reg[i]  <= (XW'(chh5_reg[i]) << SW) + (XW'(clh5_reg[i]) << (HW + 1))
                              + XW'(cll5_reg[i]);
                rl6_reg[i]   <= (XW'(r115_reg[i]) << SW)
                              + ((XW'(r015_reg[i]) + XW'(r105_reg[i])) << HW)
                              + XW'(r005_reg[i]);
                len6_reg[i]  <= len5_reg[i];
                dx6_reg[i]   <= dx5_reg[i];
                dy6_reg[i]   <= dy5_reg[i];
            end
            r1_reg   <= s_radius;
            vx1_reg  <= s_vel_x;
            vy1_reg  <= s_vel_y;
            rr2_reg  <= SW'(r1_reg) * SW'(r1_reg);
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
            rr3_reg  <= rr2_reg;
            vx3_reg  <= vx2_reg;
            vy3_reg  <= vy2_reg;
            rr4_reg  <= rr3_reg;
            vx4_reg  <= vx3_reg;
            vy4_reg  <= vy3_reg;
            vx5_reg  <= vx4_reg;
            vy5_reg  <= vy4_reg;
            vx6_reg  <= vx5_reg;
            vy6_reg  <= vy5_reg;
            item_reg <= item_next;
        end
    end

    // Touch test per edge, then the lowest touched edge wins.
    always_comb begin
        for (int i = 0; i < NE; i++) begin
            touch[i] = near6_reg[i] ? dpok6_reg[i]
                     : (far6_reg[i] ? dqok6_reg[i] : (csq6_reg[i] <= rl6_reg[i]));
        end
        item_next          = '0;
        item_next.vx       = vx6_reg;
        item_next.vy       = vy6_reg;
        for (int i = NE - 1; i >= 0; i--) begin
            if (touch[i]) begin
                item_next.hit      = 1'b1;
                item_next.edge_idx = ctb_pkg::EW'(i);
                item_next.dx       = dx6_reg[i];
                item_next.dy       = dy6_reg[i];
                item_next.len2     = len6_reg[i];
            end
        end
    end

endmodule

FILE: design/ctb_fifo.sv
// ----------------------------------------------------------------------------
// ctb_fifo
// Short queue that decouples the classifying front from the reflecting back.
// ----------------------------------------------------------------------------
module ctb_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  ctb_pkg::ctb_item_t      wdata,
    input  logic                    pop,
    output ctb_pkg::ctb_item_t      rdata,
    output ctb_pkg::ctb_fifo_stat_t stat
);

    ctb_pkg::ctb_item_t mem_reg [ctb_pkg::FD];
    logic [ctb_pkg::FAW-1:0] wptr_reg, rptr_reg;
    logic [ctb_pkg::FAW:0]   cnt_reg;

    assign stat.full  = (cnt_reg == (ctb_pkg::FAW+1)'(ctb_pkg::FD));
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem_reg[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

FILE: design/ctb_div.sv
// ----------------------------------------------------------------------------
// ctb_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module ctb_div (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [ctb_pkg::NW-1:0]  num,
    input  logic [ctb_pkg::NW-1:0]  den,
    output logic [ctb_pkg::QW:0]    q
);

    localparam int QW = ctb_pkg::QW;
    localparam int NW = ctb_pkg::NW;

    logic [NW-1:0] rem_reg [QW];
    logic [NW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW+1];
    logic          sat_reg [QW+1];
    logic [QW-1:0] fit;
    logic [NW-1:0] rem_nx  [QW];

    // Trial subtraction for every stage.
    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            fit[k-1]    = ((den_reg[k-1] << (QW - k)) <= rem_reg[k-1]);
            rem_nx[k-1] = fit[k-1] ? rem_reg[k-1] - (den_reg[k-1] << (QW - k))
                                   : rem_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (num >= (den << QW));
            for (int k = 1; k < QW; k++) begin
                rem_reg[k] <= rem_nx[k-1];
                den_reg[k] <= den_reg[k-1];
            end
            for (int k = 1; k <= QW; k++) begin
                q_reg[k]   <= q_reg[k-1] | (fit[k-1] ? (QW'(1) << (QW - k)) : '0);
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign q = sat_reg[QW] ? {1'b1, QW'(0)} : {1'b0, q_reg[QW]};

endmodule

FILE: design/ctb_back.sv
// ----------------------------------------------------------------------------
// ctb_back
// Reflects the velocity about the normal of the touched edge and saturates it.
// ----------------------------------------------------------------------------
module ctb_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ctb_pkg::ctb_fifo_stat_t fifo_stat,
    input  ctb_pkg::ctb_item_t      fifo_item,
    output logic                    fifo_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output logic [ctb_pkg::EW-1:0]  m_edge_index,
    output ctb_pkg::coord_t         m_new_vel_x,
    output ctb_pkg::coord_t         m_new_vel_y
);

    localparam int QW = ctb_pkg::QW;
    localparam int HW = ctb_pkg::HW;
    localparam int SW = ctb_pkg::SW;
    localparam int NW = ctb_pkg::NW;
    localparam int NB = 5 + QW + 1;

    logic          en;
    logic [NB-1:0] vld_reg;
    logic          m_valid_reg;

    ctb_pkg::ctb_item_t item1_reg, item2_reg, item3_reg, item4_reg;
    ctb_pkg::prod_t     vydx1_reg, vxdy1_reg;
    ctb_pkg::sum_t      k2_reg;
    ctb_pkg::usum_t     ak3_reg;
    logic [ctb_pkg::DW-1:0] adx3_reg, ady3_reg;
    logic               sgx3_reg, sgy3_reg, sgx4_reg, sgy4_reg;
    logic [ctb_pkg::MW-1:0] pxl4_reg, pxh4_reg, pyl4_reg, pyh4_reg;
    logic [NW-1:0]      numx5_reg, numy5_reg, den5_reg;
    ctb_pkg::ctb_side_t side5_reg;
    ctb_pkg::ctb_side_t sd_reg [QW+1];
    logic [QW:0]        qx, qy;
    logic               hit_reg;
    logic [ctb_pkg::EW-1:0] edge_reg;
    ctb_pkg::coord_t    nvx_reg, nvy_reg;

    // The back stalls as one piece when the result is not taken.
    assign en       = !m_valid_reg || m_ready;
    assign fifo_pop = en && !fifo_stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NB-2:0], !fifo_stat.empty};
            m_valid_reg <= vld_reg[NB-1];
        end
    end

    // Velocity dot normal, split products of the correction numerators.
    always_ff @(posedge aclk) begin
        if (en) begin
            item1_reg <= fifo_item;
            vydx1_reg <= ctb_pkg::PW'(fifo_item.vy) * ctb_pkg::PW'(fifo_item.dx);
            vxdy1_reg <= ctb_pkg::PW'(fifo_item.vx) * ctb_pkg::PW'(fifo_item.dy);

            item2_reg <= item1_reg;
            k2_reg    <= SW'(vydx1_reg) - SW'(vxdy1_reg);

            item3_reg <= item2_reg;
            ak3_reg   <= k2_reg[SW-1] ? $unsigned(-k2_reg) : $unsigned(k2_reg);
            adx3_reg  <= item2_reg.dx[ctb_pkg::DW-1] ? $unsigned(-item2_reg.dx)
                                                     : $unsigned(item2_reg.dx);
            ady3_reg  <= item2_reg.dy[ctb_pkg::DW-1] ? $unsigned(-item2_reg.dy)
                                                     : $unsigned(item2_reg.dy);
            sgx3_reg  <= k2_reg[SW-1] ^ item2_reg.dy[ctb_pkg::DW-1];
            sgy3_reg  <= k2_reg[SW-1] ^ item2_reg.dx[ctb_pkg::DW-1];

            item4_reg <= item3_reg;
            sgx4_reg  <= sgx3_reg;
            sgy4_reg  <= sgy3_reg;
            pxl4_reg  <= ak3_reg[HW-1:0] * ady3_reg;
            pxh4_reg  <= ak3_reg[SW-1:HW] * ady3_reg;
            pyl4_reg  <= ak3_reg[HW-1:0] * adx3_reg;
            pyh4_reg  <= ak3_reg[SW-1:HW] * adx3_reg;

            // Dividend 4|k c| + len2 and divisor 2 len2 give rounding to nearest.
            numx5_reg <= (NW'(pxh4_reg) << (HW + 2)) + (NW'(pxl4_reg) << 2)
                       + NW'(item4_reg.len2);
            numy5_reg <= (NW'(pyh4_reg) << (HW + 2)) + (NW'(pyl4_reg) << 2)
                       + NW'(item4_reg.len2);
            den5_reg  <= NW'(item4_reg.len2) << 1;
            side5_reg.lz       <= (item4_reg.len2 == '0);
            side5_reg.hit      <= item4_reg.hit;
            side5_reg.edge_idx <= item4_reg.edge_idx;
            side5_reg.sgx      <= sgx4_reg;
            side5_reg.sgy      <= sgy4_reg;
            side5_reg.vx       <= item4_reg.vx;
            side5_reg.vy       <= item4_reg.vy;

            sd_reg[0] <= side5_reg;
            for (int k = 1; k <= QW; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    ctb_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (numx5_reg),
        .den  (den5_reg),
        .q    (qx)
    );

    ctb_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (numy5_reg),
        .den  (den5_reg),
        .q    (qy)
    );

    // Output register: apply the corrections unless there is nothing to reflect.
    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg  <= sd_reg[QW].hit;
            edge_reg <= sd_reg[QW].edge_idx;
            if (sd_reg[QW].hit && !sd_reg[QW].lz) begin
                nvx_reg <= ctb_pkg::sat_add(sd_reg[QW].vx, sd_reg[QW].sgx, qx);
                nvy_reg <= ctb_pkg::sat_add(sd_reg[QW].vy, !sd_reg[QW].sgy, qy);
            end else begin
                nvx_reg <= sd_reg[QW].vx;
                nvy_reg <= sd_reg[QW].vy;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = hit_reg;
    assign m_edge_index = edge_reg;
    assign m_new_vel_x  = nvx_reg;
    assign m_new_vel_y  = nvy_reg;

endmodule

FILE: design/circle_triangle_bounce_top.sv
// Path: a request is accepted at the edge that loads the first front stage; it then
// passes 6 more front stages, the queue write, 5 back stages, 27 divider stages and
// the output register. Throughput: one request per cycle when the output is taken
// and the queue is not full, set by the fully pipelined front and back.
// Reset: aresetn is synchronous and active low; it empties the pipelines and queue.
// ----------------------------------------------------------------------------
// circle_triangle_bounce_top
// Circle against triangle edge collision with velocity reflection.
// ----------------------------------------------------------------------------
module circle_triangle_bounce_top (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ctb_pkg::coord_t        s_center_x,
    input  ctb_pkg::coord_t        s_center_y,
    input  logic [ctb_pkg::RW-1:0] s_radius,
    input  ctb_pkg::coord_t        s_vel_x,
    input  ctb_pkg::coord_t        s_vel_y,
    input  ctb_pkg::coord_t        s_vert0_x,
    input  ctb_pkg::coord_t        s_vert0_y,
    input  ctb_pkg::coord_t        s_vert1_x,
    input  ctb_pkg::coord_t        s_vert1_y,
    input  ctb_pkg::coord_t        s_vert2_x,
    input  ctb_pkg::coord_t        s_vert2_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [ctb_pkg::EW-1:0] m_edge_index,
    output ctb_pkg::coord_t        m_new_vel_x,
    output ctb_pkg::coord_t        m_new_vel_y
);

    ctb_pkg::ctb_fifo_stat_t fifo_stat;
    ctb_pkg::ctb_item_t      push_item, head_item;
    logic                    fifo_push, fifo_pop;

    ctb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius   (s_radius),
        .s_vel_x    (s_vel_x),
        .s_vel_y    (s_vel_y),
        .s_vert0_x  (s_vert0_x),
        .s_vert0_y  (s_vert0_y),
        .s_vert1_x  (s_vert1_x),
        .s_vert1_y  (s_vert1_y),
        .s_vert2_x  (s_vert2_x),
        .s_vert2_y  (s_vert2_y),
        .fifo_stat  (fifo_stat),
        .fifo_push  (fifo_push),
        .fifo_item  (push_item)
    );

    ctb_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .wdata   (push_item),
        .pop     (fifo_pop),
        .rdata   (head_item),
        .stat    (fifo_stat)
    );

    ctb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_stat    (fifo_stat),
        .fifo_item    (head_item),
        .fifo_pop     (fifo_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_edge_index (m_edge_index),
        .m_new_vel_x  (m_new_vel_x),
        .m_new_vel_y  (m_new_vel_y)
    );

    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> !fifo_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> !fifo_stat.empty)
        else $error("queue read while empty");

    // A miss always reports the first edge.
    a_miss_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_edge_index == '0))
        else $error("edge index set without a hit");

    // The edge index always names one of the triangle's edges.
    a_edge_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_edge_index != 2'b11))
        else $error("edge index out of range");

endmodule
